// ===== hdl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Types, codes and defaults shared by the ARP cache and responder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

  // Default cache depth
  localparam int CACHE_ENTRIES_DEF = 8;

  // Action codes of an input item
  localparam logic [1:0] ACT_PACKET = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_ADD    = 2'd2;

  // ARP operation codes
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  // Lookup status codes
  localparam logic [1:0] LK_MISS    = 2'd0;
  localparam logic [1:0] LK_PENDING = 2'd1;
  localparam logic [1:0] LK_HIT     = 2'd2;

  // Configuration register indexes
  localparam logic CFG_STATION_IP  = 1'b0;
  localparam logic CFG_STATION_MAC = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] opcode;
    logic [31:0] peer_ip;
    logic [47:0] peer_mac;
    logic [31:0] target_ip;
  } in_item_t;

  typedef struct packed {
    logic        reply_send;
    logic [31:0] reply_dest_ip;
    logic [47:0] reply_dest_mac;
    logic [1:0]  lookup_status;
    logic [47:0] lookup_mac;
    logic        entry_added;
    logic        entry_resolved;
  } out_item_t;

  // One cache entry; address zero marks an empty entry
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic        valid;
  } entry_t;

  // Write command from the sequencer to the entry store
  typedef struct packed {
    logic push;    // shift a new entry in at the front
    logic update;  // rewrite the entry at a given slot
  } store_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/arpc_chan_if.sv =====
// ----------------------------------------------------------------------------
// arpc_chan_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface arpc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/arpc_store.sv =====
// ----------------------------------------------------------------------------
// arpc_store
// Entry memory organized as a ring with a moving head. Pushing an entry moves
// the head back one slot and overwrites the oldest entry there. Reads are by
// age (0 is newest) and return the entry registered in the next cycle, with its slot.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_store #(
  parameter int CacheEntries = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [$clog2(CacheEntries)-1:0] rd_age_i,
  input  arpc_pkg::store_cmd_t         cmd_i,
  input  wire [$clog2(CacheEntries)-1:0] upd_slot_i,
  input  arpc_pkg::entry_t             wr_entry_i,
  output arpc_pkg::entry_t             rd_entry_o,
  output logic [$clog2(CacheEntries)-1:0] rd_slot_o
);
  import arpc_pkg::*;

  localparam int IW  = $clog2(CacheEntries);
  localparam int IW1 = IW + 1;
  localparam logic [IW:0]   DEPTH    = IW1'(CacheEntries);
  localparam logic [IW-1:0] LAST_IDX = IW'(CacheEntries - 1);

  entry_t            mem_q [CacheEntries];
  logic [CacheEntries-1:0] used_q, used_d;
  logic [IW-1:0]     head_q, head_d;
  logic [IW-1:0]     head_dec;
  logic [IW:0]       rd_sum;
  logic [IW-1:0]     rd_slot;
  logic [IW-1:0]     wr_slot;
  logic              wr_en;
  entry_t            rd_ent_q;
  logic              rd_used_q;
  logic [IW-1:0]     rd_slot_q;

  // Map age to slot: (head + age) wrapped at the depth
  always_comb begin
    rd_sum = {1'b0, head_q} + {1'b0, rd_age_i};
    if (rd_sum >= DEPTH) begin
      rd_sum = rd_sum - DEPTH;
    end
    rd_slot = rd_sum[IW-1:0];
  end

  // Pick the write slot: new front slot on push, else the given slot
  always_comb begin
    head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
    wr_en    = cmd_i.push || cmd_i.update;
    wr_slot  = cmd_i.push ? head_dec : upd_slot_i;
    head_d   = cmd_i.push ? head_dec : head_q;
    used_d   = used_q;
    if (cmd_i.push) begin
      used_d[wr_slot] = 1'b1;
    end
  end

  // Hold head pointer and slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      used_q <= '0;
    end else begin
      head_q <= head_d;
      used_q <= used_d;
    end
  end

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_slot] <= wr_entry_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_ent_q  <= mem_q[rd_slot];
    rd_used_q <= used_q[rd_slot];
    rd_slot_q <= rd_slot;
  end

  // An untouched slot reads as an empty entry
  assign rd_entry_o = rd_used_q ? rd_ent_q : '0;
  assign rd_slot_o  = rd_slot_q;

endmodule

`default_nettype wire

// ===== hdl/arp_cache_responder_core.sv =====
// ----------------------------------------------------------------------------
// arp_cache_responder_core
// IPv4 ARP cache and responder with a newest-first entry ring.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one item per action: a received ARP packet, an outbound
//   lookup or a pending entry to add. rsp_o returns exactly one result item
//   for every accepted item, in order. The user writes the station IP through the
//   cfg_* port while the block is idle (the block does not enforce this); the
//   station MAC is taken but not stored: the reply source is not in the result.
// Timing:
//   An add, an unused action or an ignored opcode goes from the accept
//   step straight to the finish step, which loads its result into the
//   output register. A packet or lookup scans the cache one entry per cycle
//   with a single address comparator, newest first, and stops at a match,
//   an empty entry or the end, after 1 to CacheEntries entries. One item at a
//   time; req_i.ready is high only while the block waits for an item.
// Reset:
//   Asynchronous, active low. The cache comes up empty, the station IP is zero.
// Stalls:
//   A result waits in the output register while rsp_o.ready is low; the
//   next item is accepted meanwhile, and its result is held back until the
//   register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_responder_core #(
  parameter int CacheEntries = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  arpc_chan_if.sink         req_i,
  arpc_chan_if.source       rsp_o,
  input  wire               cfg_we_i,
  input  wire               cfg_idx_i,
  input  wire [47:0]        cfg_data_i
);
  import arpc_pkg::*;

  localparam int IW = $clog2(CacheEntries);
  localparam logic [IW-1:0] LAST_IDX = IW'(CacheEntries - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]    state_q, state_d;
  in_item_t      item_q, item_d;
  logic [IW-1:0] scan_q, scan_d;
  logic          found_q, found_d;
  logic [IW-1:0] hit_slot_q, hit_slot_d;
  entry_t        hit_q, hit_d;
  out_item_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   station_ip_q;

  logic          accept;
  logic          finish_go;
  logic [IW-1:0] rd_age;
  entry_t        rd_entry;
  logic [IW-1:0] rd_slot;
  store_cmd_t    cmd;
  store_cmd_t    cmd_raw;
  entry_t        wr_entry;
  out_item_t     res;
  logic          needs_scan;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_ip_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == CFG_STATION_IP)) begin
      station_ip_q <= cfg_data_i[31:0];
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign finish_go   = (state_q == ST_FINISH) && (!out_valid_q || rsp_o.ready);

  // Only packets with a known opcode and lookups search the cache
  always_comb begin
    needs_scan = 1'b0;
    if (req_i.data.action == ACT_LOOKUP) begin
      needs_scan = 1'b1;
    end else if (req_i.data.action == ACT_PACKET) begin
      needs_scan = (req_i.data.opcode == OP_REQUEST) ||
                   (req_i.data.opcode == OP_REPLY);
    end
  end

  // Read the newest entry at acceptance, then one entry ahead each scan cycle
  assign rd_age = (state_q == ST_SCAN) ? scan_q + 1'b1 : '0;

  arpc_store #(
    .CacheEntries(CacheEntries)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_age_i   (rd_age),
    .cmd_i      (cmd),
    .upd_slot_i (hit_slot_q),
    .wr_entry_i (wr_entry),
    .rd_entry_o (rd_entry),
    .rd_slot_o  (rd_slot)
  );

  // Sequencer: accept, scan with the shared comparator, finish
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    scan_d     = scan_q;
    found_d    = found_q;
    hit_slot_d = hit_slot_q;
    hit_d      = hit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d  = req_i.data;
          scan_d  = '0;
          found_d = 1'b0;
          state_d = needs_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        priority if (rd_entry.ip == '0) begin
          state_d = ST_FINISH;
        end else if (rd_entry.ip == item_q.peer_ip) begin
          found_d    = 1'b1;
          hit_slot_d = rd_slot;
          hit_d      = rd_entry;
          state_d    = ST_FINISH;
        end else if (scan_q == LAST_IDX) begin
          state_d = ST_FINISH;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Build the result and the cache write for the finished item
  always_comb begin
    res      = '0;
    cmd_raw  = '0;
    wr_entry = '0;
    unique case (item_q.action)
      ACT_PACKET: begin
        if (item_q.opcode == OP_REQUEST) begin
          if (found_q) begin
            cmd_raw.update = 1'b1;
            wr_entry       = '{ip: hit_q.ip, mac: item_q.peer_mac, valid: hit_q.valid};
          end
          if (item_q.target_ip == station_ip_q) begin
            if (!found_q) begin
              cmd_raw.push    = 1'b1;
              wr_entry        = '{ip: item_q.peer_ip, mac: item_q.peer_mac, valid: 1'b1};
              res.entry_added = 1'b1;
            end
            res.reply_send     = 1'b1;
            res.reply_dest_ip  = item_q.peer_ip;
            res.reply_dest_mac = item_q.peer_mac;
          end
        end else if (item_q.opcode == OP_REPLY) begin
          if (found_q) begin
            cmd_raw.update     = 1'b1;
            wr_entry           = '{ip: hit_q.ip, mac: item_q.peer_mac, valid: 1'b1};
            res.entry_resolved = 1'b1;
          end
        end
      end
      ACT_LOOKUP: begin
        if (found_q && hit_q.valid) begin
          res.lookup_status = LK_HIT;
          res.lookup_mac    = hit_q.mac;
        end else if (found_q) begin
          res.lookup_status = LK_PENDING;
        end else begin
          res.lookup_status = LK_MISS;
        end
      end
      ACT_ADD: begin
        cmd_raw.push    = 1'b1;
        wr_entry        = '{ip: item_q.peer_ip, mac: 48'd0, valid: 1'b0};
        res.entry_added = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
    cmd.push   = cmd_raw.push && finish_go;
    cmd.update = cmd_raw.update && finish_go;
  end

  // Output register: load on finish, drop when taken
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (finish_go) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      found_q     <= found_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    hit_slot_q <= hit_slot_d;
    hit_q      <= hit_d;
    out_q      <= out_d;
  end

  // A cache write never both pushes and rewrites a slot
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.push && cmd.update))
    else $error("store push and update in the same cycle");

  // A new result appears only out of the finish step
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result loaded outside the finish step");

  // The scan index stays inside the cache
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_q <= LAST_IDX))
    else $error("scan index beyond the last entry");

  // A hit always names an entry that carries the searched address
  a_hit_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && found_q) |-> (hit_q.ip == item_q.peer_ip))
    else $error("recorded hit does not match the searched address");

endmodule

`default_nettype wire

// ===== verif/tb_arp_cache_responder_core.sv =====
// ----------------------------------------------------------------------------
// tb_arp_cache_responder_core
// Self-checking bench for the ARP cache and responder core. A queue-fed
// driver sends packets, lookups and pending adds in random bursts. Every
// accepted item runs through a newest-first cache predictor. A monitor
// stalls the result channel on a rotating pattern and checks each result,
// field by field, against the oldest prediction. The station address is
// rewritten between phases, extremes included.
// ----------------------------------------------------------------------------

module tb_arp_cache_responder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import arpc_pkg::*;

  localparam int CACHE_DEPTH = CACHE_ENTRIES_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int POOL_SIZE   = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_idx;
  logic [47:0] cfg_data;

  arpc_chan_if #(.T(in_item_t))  req_if ();
  arpc_chan_if #(.T(out_item_t)) rsp_if ();

  arp_cache_responder_core #(
    .CacheEntries (CACHE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted cache contents and station registers
  entry_t      cache [CACHE_DEPTH] = '{default: '0};
  logic [31:0] station_ip  = '0;
  logic [47:0] station_mac = '0;

  in_item_t    action_q [$];
  out_item_t   answer_q [$];
  int          fault_cnt = 0;

  // Index of the first matching entry ahead of any empty one, else -1
  function automatic int find_slot(logic [31:0] ip);
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (cache[i].ip == '0) return -1;
      if (cache[i].ip == ip) return i;
    end
    return -1;
  endfunction

  // Shift every entry back one place and drop the oldest
  function automatic void push_entry(logic [31:0] ip, logic [47:0] mac, logic vld);
    for (int i = CACHE_DEPTH - 1; i > 0; i--) cache[i] = cache[i-1];
    cache[0] = '{ip: ip, mac: mac, valid: vld};
  endfunction

  // Apply one item to the predicted cache and return its result
  function automatic out_item_t resolve_arp(in_item_t it);
    out_item_t ans;
    int        slot;
    ans = '0;
    case (it.action)
      ACT_PACKET: begin
        if (it.opcode == OP_REQUEST) begin
          slot = find_slot(it.peer_ip);
          if (slot >= 0) cache[slot].mac = it.peer_mac;
          if (it.target_ip == station_ip) begin
            if (slot < 0) begin
              push_entry(it.peer_ip, it.peer_mac, 1'b1);
              ans.entry_added = 1'b1;
            end
            ans.reply_send     = 1'b1;
            ans.reply_dest_ip  = it.peer_ip;
            ans.reply_dest_mac = it.peer_mac;
          end
        end else if (it.opcode == OP_REPLY) begin
          slot = find_slot(it.peer_ip);
          if (slot >= 0) begin
            cache[slot].mac   = it.peer_mac;
            cache[slot].valid = 1'b1;
            ans.entry_resolved = 1'b1;
          end
        end
      end
      ACT_LOOKUP: begin
        slot = find_slot(it.peer_ip);
        if (slot >= 0) begin
          if (cache[slot].valid) begin
            ans.lookup_status = LK_HIT;
            ans.lookup_mac    = cache[slot].mac;
          end else begin
            ans.lookup_status = LK_PENDING;
          end
        end
      end
      ACT_ADD: begin
        push_entry(it.peer_ip, '0, 1'b0);
        ans.entry_added = 1'b1;
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Driver: send queued items in bursts, with random gaps between bursts
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (req_if.valid && req_if.ready) answer_q.push_back(resolve_arp(req_if.data));
      if (!req_if.valid || req_if.ready) begin
        if (gap_left == 0 && action_q.size() != 0) begin
          req_if.valid <= 1'b1;
          req_if.data  <= action_q.pop_front();
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req_if.valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end
      end
    end
  end

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fault_cnt++;
    end
  endtask

  // Monitor: stall on a rotating ready mask and check every result item
  logic [15:0] rdy_mask;
  logic [31:0] mask_seed;
  int unsigned mask_age;
  out_item_t   want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rdy_mask = 16'hFFFF;
      mask_age = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (answer_q.size() == 0) begin
          $error("result item with no prediction waiting");
          fault_cnt++;
        end else begin
          want = answer_q.pop_front();
          check_field("reply_send", 48'(want.reply_send),
                      48'(rsp_if.data.reply_send));
          check_field("reply_dest_ip", 48'(want.reply_dest_ip),
                      48'(rsp_if.data.reply_dest_ip));
          check_field("reply_dest_mac", want.reply_dest_mac, rsp_if.data.reply_dest_mac);
          check_field("lookup_status", 48'(want.lookup_status),
                      48'(rsp_if.data.lookup_status));
          check_field("lookup_mac", want.lookup_mac, rsp_if.data.lookup_mac);
          check_field("entry_added", 48'(want.entry_added),
                      48'(rsp_if.data.entry_added));
          check_field("entry_resolved", 48'(want.entry_resolved),
                      48'(rsp_if.data.entry_resolved));
        end
      end
      // Pick a new mask now and then; keep at least one ready slot per turn
      if (mask_age == 0) begin
        mask_age  = $urandom_range(16, 96);
        mask_seed = $urandom;
        rdy_mask  = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (mask_seed[15:0] | 16'h0001);
      end else begin
        mask_age--;
      end
      rsp_if.ready <= rdy_mask[0];
      rdy_mask = {rdy_mask[0], rdy_mask[15:1]};
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb_arp_cache_responder_core: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  task automatic queue_item(logic [1:0] act, logic [15:0] op, logic [31:0] ip,
                            logic [47:0] mac, logic [31:0] tgt);
    in_item_t it;
    it.action    = act;
    it.opcode    = op;
    it.peer_ip   = ip;
    it.peer_mac  = mac;
    it.target_ip = tgt;
    action_q.push_back(it);
  endtask

  // Hold until every queued item is sent and every result has come back
  task automatic wait_idle();
    while (action_q.size() != 0 || req_if.valid || answer_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == CFG_STATION_IP) station_ip = val[31:0];
    else station_mac = val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_station(logic [31:0] ip, logic [47:0] mac);
    wait_idle();
    write_reg(CFG_STATION_IP, {16'h0000, ip});
    write_reg(CFG_STATION_MAC, mac);
  endtask

  // Mostly well-formed traffic over a small address pool; some noise on top
  task automatic random_traffic(int n);
    logic [31:0] pool [POOL_SIZE];
    logic [31:0] ip;
    int          live;
    int          pick;
    foreach (pool[i]) pool[i] = $urandom;
    live = 0;
    while (live < n) begin
      pick = $urandom_range(0, 99);
      ip   = pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 25) begin
        queue_item(ACT_ADD, 16'($urandom), ip, rand48(), $urandom);
      end else if (pick < 45) begin
        queue_item(ACT_PACKET, OP_REPLY, ip, rand48(), $urandom);
      end else if (pick < 65) begin
        queue_item(ACT_PACKET, OP_REQUEST, ip, rand48(),
                   ($urandom_range(0, 4) < 3) ? station_ip : $urandom);
      end else if (pick < 90) begin
        queue_item(ACT_LOOKUP, 16'($urandom), ip, rand48(), $urandom);
      end else begin
        queue_item(2'($urandom_range(0, 3)),
                   16'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 3)),
                   ($urandom_range(0, 5) == 0) ? 32'h0 : $urandom,
                   rand48(), $urandom);
      end
      if (pick < 90) live++;
    end
  endtask

  // Stimulus and end of run
  initial begin
    logic [31:0] ip_a;
    logic [31:0] ip_b;
    ip_a = 32'hC0A8_0001;
    ip_b = 32'hC0A8_0002;

    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_STATION_IP;
    cfg_data     = '0;
    rst_ni       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_station(32'h0A00_0001, 48'h0211_2233_4455);

    // Basic learn, resolve and merge flow
    queue_item(ACT_LOOKUP, OP_REQUEST, ip_a, '0, '0);
    queue_item(ACT_PACKET, OP_REPLY, ip_a, rand48(), station_ip);
    queue_item(ACT_PACKET, OP_REQUEST, ip_a, 48'h0A0A_0A0A_0A0A, station_ip);
    queue_item(ACT_LOOKUP, '0, ip_a, '0, '0);
    queue_item(ACT_ADD, '0, ip_b, rand48(), '0);
    queue_item(ACT_LOOKUP, '0, ip_b, '0, '0);
    queue_item(ACT_PACKET, OP_REQUEST, ip_b, 48'h0B0B_0B0B_0B0B, 32'h0A00_0002);
    queue_item(ACT_LOOKUP, '0, ip_b, '0, '0);
    queue_item(ACT_PACKET, OP_REPLY, ip_b, 48'h0C0C_0C0C_0C0C, '0);
    queue_item(ACT_LOOKUP, '0, ip_b, '0, '0);
    queue_item(ACT_PACKET, OP_REQUEST, ip_a, 48'h0D0D_0D0D_0D0D, station_ip);
    // Ignored opcodes and the unused action
    queue_item(ACT_PACKET, 16'h0000, ip_a, rand48(), station_ip);
    queue_item(ACT_PACKET, 16'hFFFF, ip_a, rand48(), station_ip);
    queue_item(ACT_PACKET, 16'h0003, ip_b, rand48(), station_ip);
    queue_item(2'b11, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    // Address zero: never matches, and once added it hides older entries
    queue_item(ACT_LOOKUP, '0, 32'h0, '0, '0);
    queue_item(ACT_PACKET, OP_REQUEST, 32'h0, 48'h0E0E_0E0E_0E0E, station_ip);
    queue_item(ACT_LOOKUP, '0, ip_a, '0, '0);
    // All-ones fields
    queue_item(ACT_ADD, '0, 32'hFFFF_FFFF, '0, '0);
    queue_item(ACT_LOOKUP, '0, 32'hFFFF_FFFF, '0, '0);
    queue_item(ACT_PACKET, OP_REPLY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(ACT_LOOKUP, '0, 32'hFFFF_FFFF, '0, '0);
    queue_item(ACT_PACKET, OP_REQUEST, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
    queue_item(ACT_ADD, 16'hFFFF, 32'h0, 48'hFFFF_FFFF_FFFF, '0);
    queue_item(ACT_PACKET, OP_REQUEST, 32'h0102_0304, '0, station_ip);

    // Random phases under several station settings
    set_station(32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    random_traffic(225);
    set_station(32'hFFFF_FFFF, 48'h0000_0000_0000);
    random_traffic(225);
    set_station($urandom, rand48());
    random_traffic(225);

    // Drain and let any stray result show up
    wait_idle();
    repeat (CACHE_DEPTH + 6) @(posedge clk_i);
    if (fault_cnt == 0 && answer_q.size() == 0) begin
      $display("tb_arp_cache_responder_core: done, clean");
    end else begin
      $display("tb_arp_cache_responder_core: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/arpc_pkg.sv
hdl/arpc_chan_if.sv
hdl/arpc_store.sv
hdl/arp_cache_responder_core.sv
verif/tb_arp_cache_responder_core.sv
